@@ design/note_and_gate_pulse_driver_macros.svh @@
// Assertion macros for the note and gate pulse driver checker.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef NOTE_AND_GATE_PULSE_DRIVER_MACROS_SVH
`define NOTE_AND_GATE_PULSE_DRIVER_MACROS_SVH

// Check a property on every rising edge outside reset
`define NGPD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check a property on every rising edge, reset included
`define NGPD_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/ngpd_pkg.sv @@
// Shared types and constants of the note and gate pulse driver.
// No dependencies; used by every module of the block.
package ngpd_pkg;

	// Defaults of the block parameters
	localparam int CHANNELS_DEF   = 12;
	localparam int COUNT_BITS_DEF = 10;
	localparam int CV_BITS_DEF    = 10;

	// Fixed field widths
	localparam int NOTE_W      = 7;
	localparam int PULSE_W     = 10;
	localparam int CV_W        = 10;
	localparam int OUT_LINES   = 12;
	localparam int CH_FIELD_W  = 5;   // holds any channel index up to 31
	localparam int QUEUE_DEPTH = 2;

	// Register reset values
	localparam logic [NOTE_W-1:0]  NOTE_BASE_RST   = 7'd36;
	localparam logic [PULSE_W-1:0] PULSE_TICKS_RST = 10'd30;

	// Register indexes
	localparam logic [0:0] REG_NOTE_BASE   = 1'b0;
	localparam logic [0:0] REG_PULSE_TICKS = 1'b1;

	// Note kinds
	localparam logic NOTE_ON = 1'b1;

	// Input action codes
	typedef enum logic [1:0] {
		ACT_TICK = 2'd0,
		ACT_NOTE = 2'd1,
		ACT_CV   = 2'd2
	} action_t;

	// Classified operation handed from front to back
	typedef enum logic [1:0] {
		OP_IDLE,
		OP_TICK,
		OP_NOTE,
		OP_GATE
	} op_kind_t;

	typedef struct packed {
		op_kind_t              kind;
		logic                  fire;
		logic [CH_FIELD_W-1:0] ch;
		logic [NOTE_W-1:0]     note;
		logic [NOTE_W-1:0]     vel;
	} op_t;

endpackage

@@ design/ngpd_front.sv @@
// Front end: classifies each input word into a tick, note update or channel fire.
// Keeps the prior gate level for edge detection. Depends on ngpd_pkg.
module ngpd_front #(
	parameter int CHANNELS = ngpd_pkg::CHANNELS_DEF,
	parameter int CV_BITS  = ngpd_pkg::CV_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic [1:0]                    action,
	input  logic                          note_kind,
	input  logic [ngpd_pkg::NOTE_W-1:0]   note_number,
	input  logic [ngpd_pkg::NOTE_W-1:0]   velocity,
	input  logic [ngpd_pkg::CV_W-1:0]     cv_level,
	input  logic                          gate_level,
	input  logic [ngpd_pkg::NOTE_W-1:0]   note_base,
	output ngpd_pkg::op_t                 op
);

	localparam int PROD_W = CV_BITS + 6;

	logic                prior_gate_q;
	logic [CV_BITS-1:0]  cv_m;
	logic [PROD_W-1:0]   prod;
	logic [7:0]          diff;
	logic                note_on;
	logic                in_window;

	// Classify the word
	always_comb begin
		cv_m      = CV_BITS'(cv_level);
		prod      = PROD_W'(cv_m) * PROD_W'(CHANNELS);
		diff      = {1'b0, note_number} - {1'b0, note_base};
		note_on   = (note_kind == ngpd_pkg::NOTE_ON) && (velocity != '0);
		in_window = !diff[7] && (diff < 8'(CHANNELS));
		op.kind   = ngpd_pkg::OP_IDLE;
		op.fire   = 1'b0;
		op.ch     = '0;
		op.note   = note_number;
		op.vel    = note_on ? velocity : '0;
		unique case (action)
			ngpd_pkg::ACT_TICK: begin
				op.kind = ngpd_pkg::OP_TICK;
			end
			ngpd_pkg::ACT_NOTE: begin
				op.kind = ngpd_pkg::OP_NOTE;
				op.fire = note_on && in_window;
				op.ch   = ngpd_pkg::CH_FIELD_W'(diff);
			end
			ngpd_pkg::ACT_CV: begin
				op.kind = ngpd_pkg::OP_GATE;
				op.fire = prior_gate_q && !gate_level;
				op.ch   = ngpd_pkg::CH_FIELD_W'(prod >> CV_BITS);
			end
			default: begin
				op.kind = ngpd_pkg::OP_IDLE;
			end
		endcase
	end

	// Track the gate level of each cv word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prior_gate_q <= 1'b1;
		end else if (accept && (action == ngpd_pkg::ACT_CV)) begin
			prior_gate_q <= gate_level;
		end
	end

endmodule

@@ design/ngpd_queue.sv @@
// Two-entry queue between the front end and the back end.
// Depends on ngpd_pkg for the operation word type.
module ngpd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  ngpd_pkg::op_t wr_data,
	input  logic          pop,
	output logic          full,
	output logic          rd_valid,
	output ngpd_pkg::op_t rd_data
);

	localparam int PTR_W = $clog2(ngpd_pkg::QUEUE_DEPTH);
	localparam int CNT_W = $clog2(ngpd_pkg::QUEUE_DEPTH + 1);

	ngpd_pkg::op_t     slot_q [ngpd_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full     = (count_q == CNT_W'(ngpd_pkg::QUEUE_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data  = slot_q[rd_ptr_q];

	// Store pushed words
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ design/ngpd_back.sv @@
// Back end: runs the channel countdowns, holds the latest note and
// registers one result word per operation. Depends on ngpd_pkg.
module ngpd_back #(
	parameter int CHANNELS   = ngpd_pkg::CHANNELS_DEF,
	parameter int COUNT_BITS = ngpd_pkg::COUNT_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             ent_valid,
	input  ngpd_pkg::op_t                    ent,
	input  logic [ngpd_pkg::PULSE_W-1:0]     pulse_ticks,
	input  logic                             out_stall,
	output logic                             pop,
	output logic                             out_valid,
	output logic [ngpd_pkg::OUT_LINES-1:0]   drive_lines,
	output logic                             note_seen,
	output logic [ngpd_pkg::NOTE_W-1:0]      recent_note,
	output logic [ngpd_pkg::NOTE_W-1:0]      recent_velocity
);

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	logic [COUNT_BITS-1:0]          cnt_q [CHANNELS];
	logic [COUNT_BITS-1:0]          cnt_d [CHANNELS];
	logic [COUNT_BITS-1:0]          load;
	logic [15:0]                    pulse_wide;
	logic [ngpd_pkg::OUT_LINES-1:0] lines_d;
	logic                           seen_q;
	logic [ngpd_pkg::NOTE_W-1:0]    note_q;
	logic [ngpd_pkg::NOTE_W-1:0]    vel_q;
	logic                           seen_d;
	logic [ngpd_pkg::NOTE_W-1:0]    note_d;
	logic [ngpd_pkg::NOTE_W-1:0]    vel_d;
	logic                           out_valid_q;
	logic [ngpd_pkg::OUT_LINES-1:0] lines_q;
	logic                           seen_out_q;
	logic [ngpd_pkg::NOTE_W-1:0]    note_out_q;
	logic [ngpd_pkg::NOTE_W-1:0]    vel_out_q;

	// Take a word whenever the result register is free or being emptied
	assign pop = ent_valid && (!out_valid_q || !out_stall);

	// Saturate the pulse length to the counter
	always_comb begin
		pulse_wide = 16'(pulse_ticks);
		load = (pulse_wide > 16'(COUNT_MAX)) ? COUNT_MAX : COUNT_BITS'(pulse_wide);
	end

	// Next countdown of every channel
	always_comb begin
		for (int i = 0; i < CHANNELS; i++) begin
			cnt_d[i] = cnt_q[i];
			if ((ent.kind == ngpd_pkg::OP_TICK) && (cnt_q[i] != '0)) begin
				cnt_d[i] = cnt_q[i] - 1'b1;
			end
			if (ent.fire && (ent.ch == ngpd_pkg::CH_FIELD_W'(i))) begin
				cnt_d[i] = load;
			end
		end
	end

	// Visible lines: only the first twelve channels
	for (genvar gi = 0; gi < ngpd_pkg::OUT_LINES; gi++) begin : g_line
		if (gi < CHANNELS) begin : g_used
			assign lines_d[gi] = (cnt_d[gi] != '0);
		end else begin : g_none
			assign lines_d[gi] = 1'b0;
		end
	end

	// Next note store
	always_comb begin
		seen_d = seen_q;
		note_d = note_q;
		vel_d  = vel_q;
		if (ent.kind == ngpd_pkg::OP_NOTE) begin
			seen_d = 1'b1;
			note_d = ent.note;
			vel_d  = ent.vel;
		end
	end

	// Hold channel and note state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				cnt_q[i] <= '0;
			end
			seen_q <= 1'b0;
			note_q <= '0;
			vel_q  <= '0;
		end else if (pop) begin
			for (int i = 0; i < CHANNELS; i++) begin
				cnt_q[i] <= cnt_d[i];
			end
			seen_q <= seen_d;
			note_q <= note_d;
			vel_q  <= vel_d;
		end
	end

	// Result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (pop) begin
			lines_q    <= lines_d;
			seen_out_q <= seen_d;
			note_out_q <= note_d;
			vel_out_q  <= vel_d;
		end
	end

	assign out_valid       = out_valid_q;
	assign drive_lines     = lines_q;
	assign note_seen       = seen_out_q;
	assign recent_note     = note_out_q;
	assign recent_velocity = vel_out_q;

endmodule

@@ design/note_and_gate_pulse_driver.sv @@
// Note and gate pulse driver: a bank of one-shot outputs fired by note
// messages and falling gate edges. Depends on ngpd_pkg and the ngpd_* modules.
//
// Use:
//   Input words (in_valid / in_stall) are a millisecond tick, a note message
//   or a cv and gate sample. Each accepted word gives exactly one result word
//   (out_valid / out_stall) with the line, note-seen and latest note state
//   after that word. The configuration port (cfg_valid / cfg_ready, always
//   ready) writes note_base (index 0) and pulse_ticks (index 1); the user must
//   write them only while idle, and the block itself does not enforce this.
//   A word is held in a queue entry and then in the result register.
//   Throughput: one word per cycle; the front end classifies, a two-entry
//   queue decouples it from the back end, which updates all countdowns at once.
//   While the receiver stalls the result register holds, the back end stops
//   and the queue fills; in_stall rises once both queue entries are taken.
//   Reset clears all countdowns, the note store and seen flag,
//   sets the prior gate level high and loads note_base 36, pulse_ticks 30.
module note_and_gate_pulse_driver #(
	parameter int CHANNELS   = ngpd_pkg::CHANNELS_DEF,
	parameter int COUNT_BITS = ngpd_pkg::COUNT_BITS_DEF,
	parameter int CV_BITS    = ngpd_pkg::CV_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [1:0]                       action,
	input  logic                             note_kind,
	input  logic [ngpd_pkg::NOTE_W-1:0]      note_number,
	input  logic [ngpd_pkg::NOTE_W-1:0]      velocity,
	input  logic [ngpd_pkg::CV_W-1:0]        cv_level,
	input  logic                             gate_level,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [ngpd_pkg::OUT_LINES-1:0]   drive_lines,
	output logic                             note_seen,
	output logic [ngpd_pkg::NOTE_W-1:0]      recent_note,
	output logic [ngpd_pkg::NOTE_W-1:0]      recent_velocity,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [0:0]                       cfg_index,
	input  logic [ngpd_pkg::PULSE_W-1:0]     cfg_data
);

	logic                          accept;
	logic                          q_full;
	logic                          q_valid;
	logic                          q_pop;
	ngpd_pkg::op_t                 front_op;
	ngpd_pkg::op_t                 q_op;
	logic [ngpd_pkg::NOTE_W-1:0]   note_base_q;
	logic [ngpd_pkg::PULSE_W-1:0]  pulse_ticks_q;

	assign cfg_ready = 1'b1;
	assign in_stall  = q_full;
	assign accept    = in_valid && !q_full;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			note_base_q   <= ngpd_pkg::NOTE_BASE_RST;
			pulse_ticks_q <= ngpd_pkg::PULSE_TICKS_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				ngpd_pkg::REG_NOTE_BASE: begin
					note_base_q <= cfg_data[ngpd_pkg::NOTE_W-1:0];
				end
				ngpd_pkg::REG_PULSE_TICKS: begin
					pulse_ticks_q <= cfg_data;
				end
				default: begin
					note_base_q <= note_base_q;
				end
			endcase
		end
	end

	ngpd_front #(
		.CHANNELS (CHANNELS),
		.CV_BITS  (CV_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.action      (action),
		.note_kind   (note_kind),
		.note_number (note_number),
		.velocity    (velocity),
		.cv_level    (cv_level),
		.gate_level  (gate_level),
		.note_base   (note_base_q),
		.op          (front_op)
	);

	ngpd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept),
		.wr_data  (front_op),
		.pop      (q_pop),
		.full     (q_full),
		.rd_valid (q_valid),
		.rd_data  (q_op)
	);

	ngpd_back #(
		.CHANNELS   (CHANNELS),
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.ent_valid       (q_valid),
		.ent             (q_op),
		.pulse_ticks     (pulse_ticks_q),
		.out_stall       (out_stall),
		.pop             (q_pop),
		.out_valid       (out_valid),
		.drive_lines     (drive_lines),
		.note_seen       (note_seen),
		.recent_note     (recent_note),
		.recent_velocity (recent_velocity)
	);

endmodule

@@ design/ngpd_checker.sv @@
// Port-level checks of the note and gate pulse driver, bound to the top level.
// Depends on note_and_gate_pulse_driver_macros.svh.
`include "note_and_gate_pulse_driver_macros.svh"

module ngpd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic       note_seen,
	input logic [6:0] recent_note,
	input logic [6:0] recent_velocity
);

	// A stalled result stays offered
	`NGPD_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "result dropped while stalled")

	// Once a note has been seen it stays seen
	`NGPD_ASSERT(a_seen_sticky, out_valid && note_seen |=> !out_valid || note_seen, "note_seen fell")

	// Before any note the store reads zero
	`NGPD_ASSERT(a_no_note, out_valid && !note_seen |-> recent_note == 7'd0 && recent_velocity == 7'd0, "note store set before any note")

	// Nothing is offered or stalled on the edge after a reset cycle
	`NGPD_ASSERT_ALWAYS(a_reset_quiet, !arst_n |=> !out_valid && !in_stall, "activity in reset")

endmodule

bind note_and_gate_pulse_driver ngpd_checker u_ngpd_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_stall        (in_stall),
	.out_valid       (out_valid),
	.out_stall       (out_stall),
	.note_seen       (note_seen),
	.recent_note     (recent_note),
	.recent_velocity (recent_velocity)
);
